// ----- rtl/core/json_string_escaper_assert.svh -----
// ----------------------------------------------------------------------------
// JSON string escaper assertion macros
// Shared concurrent assertion forms for the escaper RTL.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_ASSERT_SVH
`define JSON_STRING_ESCAPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("json_string_escaper: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define JSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("json_string_escaper: next-cycle check failed");

`endif

// ----- rtl/core/jse_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper package
// Item types and character codes shared by the escaper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

  // How a queued byte is written out.
  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,  // byte passes through unchanged
    KIND_SHORT = 2'd1,  // backslash plus one character
    KIND_LONG  = 2'd2   // backslash, u, two zeros, two hex digits
  } kind_e;

  // One classified item as it sits in the queue.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;     // original byte, or the short escape character
    logic        str_end;
  } item_t;

  // Sequence step counter, wide enough for the six-byte form.
  typedef logic [2:0] step_t;

  localparam step_t LenPass  = 3'd1;
  localparam step_t LenShort = 3'd2;
  localparam step_t LenLong  = 3'd6;

  // Character codes.
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChReturn    = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChFormFeed  = 8'h0C;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChOne       = 8'h31;
  localparam logic [7:0] CtrlLimit   = 8'h20;

endpackage

`default_nettype wire

// ----- rtl/core/json_string_escaper.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper
// Escapes a byte stream for use inside a JSON string literal.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata = in_byte [7:0]; tlast = string_end
//   m_axis    out        tdata = out_byte [7:0]; tuser = run_last;
//                        tlast = string_last
//   cfg       in         cfg_wdata_i = short_bf_escapes, written on cfg_we_i
//
// A byte that passes through gives one output byte; an escaped byte gives two
// or six, as the emitter steps through its sequence one output byte per cycle
// while the output is not stalled. Input reaches the output through the queue
// and the output register. The queue lets input run ahead while the output
// is stalled or busy with a long escape. Reset clears the queue and output
// valid, and sets short_bf_escapes to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escaper #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tuser,   // [0] run_last
  output logic        m_axis_tlast
);

  logic            short_bf_q;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  jse_pkg::item_t  wr_item;
  jse_pkg::item_t  rd_item;
  logic            in_accept;
  logic            inner_byte_ok;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_bf_q <= 1'b1;
    end else if (cfg_we_i) begin
      short_bf_q <= cfg_wdata_i;
    end
  end

  // Front end: accept and classify.
  jse_classify u_classify (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .short_bf_i (short_bf_q),
    .full_i     (full),
    .push_o     (push),
    .item_o     (wr_item)
  );

  // Queue between the two halves.
  jse_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_item),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rd_item),
    .empty_o (empty)
  );

  // Back end: emit escape sequences.
  jse_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (rd_item),
    .empty_i      (empty),
    .pop_o        (pop),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_o    (m_axis_tdata),
    .m_run_last_o (m_axis_tuser),
    .m_str_last_o (m_axis_tlast)
  );

  // Terms used by the checks below.
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign inner_byte_ok = (m_axis_tdata == jse_pkg::ChBackslash) ||
                         (m_axis_tdata == jse_pkg::ChLowerU) ||
                         (m_axis_tdata == jse_pkg::ChZero) ||
                         (m_axis_tdata == jse_pkg::ChOne);

  // Assertions.
`include "json_string_escaper_assert.svh"

  // The end of a string always coincides with the end of a sequence.
  `JSE_ASSERT_IMPL(a_str_last_ends_run, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser)

  // Bytes inside an escape sequence are only backslash, u, 0 or 1.
  `JSE_ASSERT_IMPL(a_inner_byte_set, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, inner_byte_ok)

  // Once an item is accepted, output valid follows it.
  `JSE_ASSERT_NEXT(a_output_follows, clk_i, rst_ni, in_accept, ##1 m_axis_tvalid)

endmodule

`default_nettype wire

// ----- rtl/core/jse_classify.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper front end
// Accepts input bytes and classifies each into an escape kind for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_classify (
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  logic [7:0]      s_tdata_i,
  input  logic            s_tlast_i,
  input  logic            short_bf_i,
  input  logic            full_i,
  output logic            push_o,
  output jse_pkg::item_t  item_o
);

  logic [7:0] short_char;
  logic       is_short;

  // Accept whenever the queue has room.
  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && !full_i;

  // Decode the byte into its short escape character, if it has one.
  always_comb begin
    short_char = jse_pkg::ChBackslash;
    is_short   = 1'b1;
    unique case (s_tdata_i)
      jse_pkg::ChQuote:     short_char = jse_pkg::ChQuote;
      jse_pkg::ChBackslash: short_char = jse_pkg::ChBackslash;
      jse_pkg::ChNewline:   short_char = jse_pkg::ChLowerN;
      jse_pkg::ChReturn:    short_char = jse_pkg::ChLowerR;
      jse_pkg::ChTab:       short_char = jse_pkg::ChLowerT;
      jse_pkg::ChBackspace: begin
        short_char = jse_pkg::ChLowerB;
        is_short   = short_bf_i;
      end
      jse_pkg::ChFormFeed: begin
        short_char = jse_pkg::ChLowerF;
        is_short   = short_bf_i;
      end
      default: is_short = 1'b0;
    endcase
  end

  // Build the queue entry.
  always_comb begin
    item_o.str_end = s_tlast_i;
    if (is_short) begin
      item_o.kind = jse_pkg::KIND_SHORT;
      item_o.data = short_char;
    end else if (s_tdata_i < jse_pkg::CtrlLimit) begin
      item_o.kind = jse_pkg::KIND_LONG;
      item_o.data = s_tdata_i;
    end else begin
      item_o.kind = jse_pkg::KIND_PASS;
      item_o.data = s_tdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/jse_fifo.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper item queue
// Short first-in first-out queue between the front end and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_fifo #(
  parameter int unsigned Depth = 4   // power of two, at least 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jse_pkg::item_t  wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output jse_pkg::item_t  rdata_o,
  output logic            empty_o
);

  localparam int unsigned AddrW = $clog2(Depth);

  jse_pkg::item_t   mem_q [Depth];
  logic [AddrW:0]   wptr_q, wptr_d;
  logic [AddrW:0]   rptr_q, rptr_d;

  // Pointers carry one extra wrap bit to tell full from empty.
  assign empty_o = (wptr_q == rptr_q);
  assign full_o  = (wptr_q[AddrW] != rptr_q[AddrW]) &&
                   (wptr_q[AddrW-1:0] == rptr_q[AddrW-1:0]);
  assign rdata_o = mem_q[rptr_q[AddrW-1:0]];

  // Pointer updates.
  always_comb begin
    wptr_d = push_i ? wptr_q + {{AddrW{1'b0}}, 1'b1} : wptr_q;
    rptr_d = pop_i  ? rptr_q + {{AddrW{1'b0}}, 1'b1} : rptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q[AddrW-1:0]] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/jse_emit.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper back end
// Walks the queue head through its escape sequence into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jse_pkg::item_t  item_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  output logic [7:0]      m_tdata_o,
  output logic            m_run_last_o,
  output logic            m_str_last_o
);

  jse_pkg::step_t  step_q, step_d;
  jse_pkg::step_t  seq_len;
  logic [7:0]      cur_byte;
  logic            cur_last;
  logic            load;
  logic            valid_q, valid_d;
  logic [7:0]      byte_q;
  logic            run_last_q;
  logic            str_last_q;

  // Lower-case hex digit for one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'h0, nib};
    end else begin
      res = 8'h57 + {4'h0, nib};
    end
    return res;
  endfunction

  // Sequence length and current byte of the queue head.
  always_comb begin
    seq_len  = jse_pkg::LenPass;
    cur_byte = item_i.data;
    case (item_i.kind)
      jse_pkg::KIND_PASS: begin
        seq_len  = jse_pkg::LenPass;
        cur_byte = item_i.data;
      end
      jse_pkg::KIND_SHORT: begin
        seq_len  = jse_pkg::LenShort;
        cur_byte = (step_q == '0) ? jse_pkg::ChBackslash : item_i.data;
      end
      jse_pkg::KIND_LONG: begin
        seq_len = jse_pkg::LenLong;
        case (step_q)
          3'd0:         cur_byte = jse_pkg::ChBackslash;
          3'd1:         cur_byte = jse_pkg::ChLowerU;
          3'd2, 3'd3:   cur_byte = jse_pkg::ChZero;
          3'd4:         cur_byte = hex_digit(item_i.data[7:4]);
          default:      cur_byte = hex_digit(item_i.data[3:0]);
        endcase
      end
      default: begin
        seq_len  = jse_pkg::LenPass;
        cur_byte = item_i.data;
      end
    endcase
  end

  assign cur_last = (step_q == seq_len - 3'd1);

  // Move one byte whenever the output register is free or being drained.
  assign load   = !empty_i && (!valid_q || m_tready_i);
  assign pop_o  = load && cur_last;

  always_comb begin
    step_d  = step_q;
    if (load) begin
      step_d = cur_last ? '0 : step_q + 3'd1;
    end
    valid_d = load || (valid_q && !m_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q     <= cur_byte;
      run_last_q <= cur_last;
      str_last_q <= cur_last && item_i.str_end;
    end
  end

  assign m_tvalid_o   = valid_q;
  assign m_tdata_o    = byte_q;
  assign m_run_last_o = run_last_q;
  assign m_str_last_o = str_last_q;

endmodule

`default_nettype wire
